// File: rtl/core/sec_pkg.sv
// Shared types, codes and helpers for the stepper elevator controller.
// No dependencies; imported by every module of the block.
package sec_pkg;

  localparam int POSITION_BITS = 16;
  localparam int TIMER_BITS    = 16;
  // Widths for comparing internal values against the 16 bit register fields.
  localparam int PCW = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam int TCW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  typedef logic signed [POSITION_BITS-1:0] pos_t;
  typedef logic [TIMER_BITS-1:0]           timer_t;

  localparam pos_t   POS_MAX   = {1'b0, {(POSITION_BITS-1){1'b1}}};
  localparam pos_t   POS_MIN   = {1'b1, {(POSITION_BITS-1){1'b0}}};
  localparam timer_t TIMER_MAX = {TIMER_BITS{1'b1}};

  // User commands; the remaining codes act as no command.
  localparam logic [2:0] CMD_UP     = 3'd1;
  localparam logic [2:0] CMD_DOWN   = 3'd2;
  localparam logic [2:0] CMD_AUTO   = 3'd3;
  localparam logic [2:0] CMD_MANUAL = 3'd4;

  // Mode codes as seen on the result channel.
  localparam logic [2:0] MODE_BOOT    = 3'd0;
  localparam logic [2:0] MODE_STEPOFF = 3'd1;
  localparam logic [2:0] MODE_IDLE    = 3'd2;
  localparam logic [2:0] MODE_UP      = 3'd3;
  localparam logic [2:0] MODE_DOWN    = 3'd4;
  localparam logic [2:0] MODE_AUTO    = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_BOOT_PERIOD   = 3'd0;
  localparam logic [2:0] REG_SLOW_PERIOD   = 3'd1;
  localparam logic [2:0] REG_MIDDLE_PERIOD = 3'd2;
  localparam logic [2:0] REG_FAST_PERIOD   = 3'd3;
  localparam logic [2:0] REG_SPEED_HOLD    = 3'd4;
  localparam logic [2:0] REG_UPPER_LIMIT   = 3'd5;
  localparam logic [2:0] REG_LOWER_LIMIT   = 3'd6;

  typedef struct packed {
    logic [15:0]        boot_period;
    logic [15:0]        slow_period;
    logic [15:0]        middle_period;
    logic [15:0]        fast_period;
    logic [14:0]        speed_hold;
    logic signed [15:0] upper_limit;
    logic signed [15:0] lower_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  user_command;
    logic [15:0] pressed_time;
    logic        up_limit_pressed;
    logic        auto_allowed;
    logic        laser_seen;
    logic        auto_flag;
  } tick_t;

  typedef struct packed {
    logic [2:0]  mode_code;
    logic        step_up;
    logic        step_down;
    logic        hold_platen;
    logic        auto_cancel;
    logic [15:0] step_position;
  } res_t;

  function automatic logic signed [PCW-1:0] pos_ext(input pos_t p);
    logic signed [PCW-1:0] r;
    r = PCW'(p);
    return r;
  endfunction

  function automatic logic signed [PCW-1:0] lim_ext(input logic signed [15:0] v);
    logic signed [PCW-1:0] r;
    r = PCW'(v);
    return r;
  endfunction

  function automatic logic tmr_gt(input timer_t t, input logic [15:0] per);
    logic [TCW-1:0] a;
    logic [TCW-1:0] b;
    a = TCW'(t);
    b = TCW'(per);
    return a > b;
  endfunction

endpackage

// File: rtl/core/stepper_elevator_controller.sv
// Stepper elevator controller: homes a platen against the upper limit switch,
// then runs manual and laser-guided automatic moves, one request per timer tick.
// Input channel (in_*): one tick request per accepted transfer, carrying the
// user command, button hold time, limit switch, auto-enable, laser and auto flag.
// Result channel (out_*): one result per tick with the mode, step pulses, the
// platen hold level, the auto-cancel pulse and the step position after the tick.
// Configuration channel (cfg_*): always ready; cfg_index selects the register.
// A tick accepted into the input register passes through the mode logic into
// the result register once that register is free, and out_valid is high from
// then on. Throughput is one tick per cycle while out_stall is low, as the
// registered mode, timer and position are updated once for each tick.
// When out_stall holds the result register full, the next tick waits in the
// input register and in_stall rises only once both registers are occupied.
// Synchronous reset puts the block in bootup with timer, position, auto and
// hold state cleared, loads the register defaults and empties both registers.
module stepper_elevator_controller import sec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_user_command,
  input  logic [15:0] in_pressed_time,
  input  logic        in_up_limit_pressed,
  input  logic        in_auto_allowed,
  input  logic        in_laser_seen,
  input  logic        in_auto_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_mode_code,
  output logic        out_step_up,
  output logic        out_step_down,
  output logic        out_hold_platen,
  output logic        out_auto_cancel,
  output logic signed [15:0] out_step_position,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg;
  tick_t tick_in;
  tick_t tick_r;
  res_t  res;
  res_t  res_r;
  logic  tick_valid_r;
  logic  out_valid_r;
  logic  out_free;
  logic  advance;
  logic  in_accept;

  assign cfg_ready = 1'b1;

  sec_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign tick_in.user_command     = in_user_command;
  assign tick_in.pressed_time     = in_pressed_time;
  assign tick_in.up_limit_pressed = in_up_limit_pressed;
  assign tick_in.auto_allowed     = in_auto_allowed;
  assign tick_in.laser_seen       = in_laser_seen;
  assign tick_in.auto_flag        = in_auto_flag;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = tick_valid_r && out_free;
  assign in_stall  = tick_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  sec_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (advance),
    .tick    (tick_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      tick_valid_r <= in_accept || (tick_valid_r && !advance);
      if (advance) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) tick_r <= tick_in;
    if (advance) res_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_mode_code     = res_r.mode_code;
  assign out_step_up       = res_r.step_up;
  assign out_step_down     = res_r.step_down;
  assign out_hold_platen   = res_r.hold_platen;
  assign out_auto_cancel   = res_r.auto_cancel;
  assign out_step_position = res_r.step_position;

endmodule

// File: rtl/core/sec_cfg_regs.sv
// Configuration register file of the stepper elevator controller.
// Depends on sec_pkg for the register indexes and the cfg_t bundle.
module sec_cfg_regs import sec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.boot_period   <= 16'd5;
      cfg_r.slow_period   <= 16'd20;
      cfg_r.middle_period <= 16'd10;
      cfg_r.fast_period   <= 16'd2;
      cfg_r.speed_hold    <= 15'd1000;
      cfg_r.upper_limit   <= 16'sd0;
      cfg_r.lower_limit   <= 16'sd10000;
    end else if (wr_en) begin
      case (wr_index)
        REG_BOOT_PERIOD:   cfg_r.boot_period   <= wr_data;
        REG_SLOW_PERIOD:   cfg_r.slow_period   <= wr_data;
        REG_MIDDLE_PERIOD: cfg_r.middle_period <= wr_data;
        REG_FAST_PERIOD:   cfg_r.fast_period   <= wr_data;
        REG_SPEED_HOLD:    cfg_r.speed_hold    <= wr_data[14:0];
        REG_UPPER_LIMIT:   cfg_r.upper_limit   <= wr_data;
        REG_LOWER_LIMIT:   cfg_r.lower_limit   <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/sec_core.sv
// Mode sequencer, step timer and position counter of the elevator controller.
// Depends on sec_pkg; computes one tick's result from registered state.
module sec_core import sec_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  tick_en,
  input  tick_t tick,
  input  cfg_t  cfg,
  output res_t  res
);

  typedef enum logic [2:0] {
    M_BOOT    = MODE_BOOT,
    M_STEPOFF = MODE_STEPOFF,
    M_IDLE    = MODE_IDLE,
    M_UP      = MODE_UP,
    M_DOWN    = MODE_DOWN,
    M_AUTO    = MODE_AUTO
  } mode_t;

  mode_t  mode_r, mode_nxt;
  timer_t elapsed_r, elapsed_nxt, elapsed_inc;
  pos_t   pos_r, pos_nxt;
  logic   only_up_r, only_up_nxt;
  logic   hold_r, hold_nxt;
  logic   do_up, do_down, cancel;
  logic [15:0] period;
  logic [15:0] twice_hold;
  logic        below_upper, beyond_lower, under_lower, above_zero;
  logic signed [PCW-1:0] pos_wide;

  always_comb begin
    twice_hold = {cfg.speed_hold, 1'b0};
    period = cfg.slow_period;
    if (tick.pressed_time >= twice_hold) begin
      period = cfg.fast_period;
    end else if (tick.pressed_time >= {1'b0, cfg.speed_hold}) begin
      period = cfg.middle_period;
    end
  end

  assign elapsed_inc  = (elapsed_r == TIMER_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign below_upper  = pos_ext(pos_r) <= lim_ext(cfg.upper_limit);
  assign beyond_lower = pos_ext(pos_r) >  lim_ext(cfg.lower_limit);
  assign under_lower  = pos_ext(pos_r) <  lim_ext(cfg.lower_limit);
  assign above_zero   = pos_r > pos_t'(0);

  always_comb begin
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    only_up_nxt = only_up_r;
    hold_nxt    = hold_r;
    do_up       = 1'b0;
    do_down     = 1'b0;
    cancel      = 1'b0;
    case (mode_r)
      M_STEPOFF: begin
        if (tick.up_limit_pressed) begin
          do_down = tmr_gt(elapsed_inc, cfg.slow_period);
        end else begin
          pos_nxt  = '0;
          mode_nxt = M_IDLE;
        end
      end
      M_IDLE: begin
        if (tick.user_command == CMD_AUTO) mode_nxt = M_AUTO;
        else if (tick.user_command == CMD_DOWN) mode_nxt = M_DOWN;
        else if (tick.user_command == CMD_UP) mode_nxt = M_UP;
      end
      M_UP: begin
        if (tick.user_command == CMD_AUTO || tick.auto_flag) begin
          mode_nxt = M_AUTO;
        end else if (tick.user_command == CMD_DOWN) begin
          mode_nxt = M_DOWN;
        end else if (tick.up_limit_pressed) begin
          mode_nxt = M_STEPOFF;
        end else if (tick.user_command == CMD_UP) begin
          if (below_upper) mode_nxt = M_IDLE;
          else do_up = tmr_gt(elapsed_inc, period);
        end
      end
      M_DOWN: begin
        if (tick.user_command == CMD_AUTO || tick.auto_flag) begin
          mode_nxt = M_AUTO;
        end else if (tick.user_command == CMD_UP) begin
          mode_nxt = M_UP;
        end else if (tick.user_command == CMD_DOWN) begin
          if (beyond_lower) mode_nxt = M_IDLE;
          else do_down = tmr_gt(elapsed_inc, period);
        end
      end
      M_AUTO: begin
        if ((!tick.auto_allowed && tick.auto_flag) || tick.user_command == CMD_MANUAL) begin
          cancel      = 1'b1;
          hold_nxt    = 1'b0;
          only_up_nxt = 1'b0;
          mode_nxt    = M_IDLE;
        end else begin
          // Descend until the stack is seen or the lower limit is reached.
          if (!only_up_r) begin
            if (under_lower && !tick.laser_seen) begin
              do_down = tmr_gt(elapsed_inc, cfg.middle_period);
            end else begin
              only_up_nxt = 1'b1;
            end
          end
          // A down step only happens without the laser, so these are exclusive.
          if (tick.laser_seen) begin
            hold_nxt = 1'b1;
            do_up = above_zero && !tick.up_limit_pressed &&
                    tmr_gt(elapsed_inc, cfg.slow_period);
          end else begin
            hold_nxt = 1'b0;
          end
        end
      end
      default: begin
        if (tick.up_limit_pressed) mode_nxt = M_STEPOFF;
        else do_up = tmr_gt(elapsed_inc, cfg.boot_period);
      end
    endcase

    elapsed_nxt = elapsed_inc;
    if (do_up) begin
      elapsed_nxt = '0;
      if (pos_r != POS_MIN) pos_nxt = pos_r - 1'b1;
    end
    if (do_down) begin
      elapsed_nxt = '0;
      if (pos_r != POS_MAX) pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_BOOT;
      elapsed_r <= '0;
      pos_r     <= '0;
      only_up_r <= 1'b0;
      hold_r    <= 1'b0;
    end else if (tick_en) begin
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      pos_r     <= pos_nxt;
      only_up_r <= only_up_nxt;
      hold_r    <= hold_nxt;
    end
  end

  assign pos_wide = pos_ext(pos_nxt);

  always_comb begin
    res.mode_code     = mode_nxt;
    res.step_up       = do_up;
    res.step_down     = do_down;
    res.hold_platen   = hold_nxt;
    res.auto_cancel   = cancel;
    res.step_position = pos_wide[15:0];
  end

endmodule

// File: rtl/core/sec_checker.sv
// Port-level checks for the stepper elevator controller.
// Depends on sec_pkg for mode codes; bound to the top level below.
module sec_checker import sec_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_mode_code,
  input logic        out_step_up,
  input logic        out_step_down,
  input logic        out_auto_cancel,
  input logic [15:0] out_step_position
);

  // Never both step directions in one tick.
  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_step_up && out_step_down))
    else $error("step up and step down in the same tick");

  // A cancel always drops the block back to idle.
  a_cancel_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_auto_cancel) |-> out_mode_code == MODE_IDLE)
    else $error("auto cancel without return to idle");

  // Up steps come only from homing, manual up or auto.
  a_up_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_step_up) |->
      (out_mode_code == MODE_BOOT || out_mode_code == MODE_UP ||
       out_mode_code == MODE_AUTO))
    else $error("up step in a mode that cannot step up");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_step_position) &&
                                  $stable(out_mode_code)))
    else $error("stalled result changed");

endmodule

bind stepper_elevator_controller sec_checker u_sec_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_mode_code     (out_mode_code),
  .out_step_up       (out_step_up),
  .out_step_down     (out_step_down),
  .out_auto_cancel   (out_auto_cancel),
  .out_step_position (out_step_position)
);
